// ----- hdl/ntu_pkg.sv -----
package ntu_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;

   localparam int ACT_W   = 3;
   localparam int NUM_W   = 16;
   localparam int ADDR_W  = 16;
   localparam int FOUND_W = 9;
   localparam int CSR_W   = 9;
   localparam int ENTRY_W = ADDR_W + 1;
   localparam int WIDE_W  = NUM_W + 1;

   localparam logic [CSR_W-1:0] MAX_DEVICES_RESET = 9'd256;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [ACT_W-1:0]  action_type;

   localparam action_type ACT_REPORT   = 3'd0;
   localparam action_type ACT_GET_ADDR = 3'd1;
   localparam action_type ACT_GET_NUM  = 3'd2;
   localparam action_type ACT_ASSIGN   = 3'd3;
   localparam action_type ACT_CLEAR    = 3'd4;

   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_LOOKUP,
      ST_SCAN
   } state_type;

   // valid-bit control from the sequencer
   typedef struct packed {
      logic    set_entry;
      logic    clear_addr;
      idx_type wr_idx;
      idx_type rd_idx;
   } vld_ctrl_type;

   // registered valid bit of the entry read last cycle
   typedef struct packed {
      logic addr_vld;
   } vld_stat_type;

endpackage

// ----- hdl/node_address_table_unit.sv -----
// Device table: maps device numbers 1..min(max_devices, 256) to 16-bit
// node addresses with an on/off mark per entry. Raise start with a request
// while busy is low; exactly one result follows, shown for one cycle with
// rsp_valid high, and it must be taken then since the block cannot be
// stalled. Report, clear, refused numbers and unknown actions answer in the
// next cycle and leave busy low, so a new request may follow at once.
// Address by number does one read of the entry RAM. Number by address and
// assign scan the entry RAM one entry per cycle from entry 1, stopping at
// the first hit or after entry min(max_devices, 256). The single read port
// of the entry RAM sets that scan rate. After reset, busy stays high while
// a clearing pass zeroes every entry, addresses and marks. Clear takes
// effect at once through per-entry address valid bits and keeps the marks.
module node_address_table_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [ntu_pkg::ACT_W-1:0]    req_action,
   input  logic [ntu_pkg::NUM_W-1:0]    req_device_number,
   input  logic [ntu_pkg::ADDR_W-1:0]   req_node_address,
   input  logic                         req_lamp_on,
   output logic                         rsp_valid,
   output logic                         rsp_ok,
   output logic [ntu_pkg::ADDR_W-1:0]   rsp_found_address,
   output logic [ntu_pkg::FOUND_W-1:0]  rsp_found_number,
   output logic                         rsp_mark,
   input  logic                         csr_write_enable,
   input  logic [ntu_pkg::CSR_W-1:0]    csr_write_data
);

   import ntu_pkg::*;

   state_type              state_ff, state_in;
   logic [CSR_W-1:0]       csr_max_ff;
   logic [CNT_W-1:0]       lim_ff, lim_in;
   logic [ADDR_W-1:0]      key_ff, key_in;
   idx_type                scan_idx_ff, scan_idx_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_ok_ff, rsp_ok_in;
   logic [ADDR_W-1:0]      rsp_addr_ff, rsp_addr_in;
   logic [FOUND_W-1:0]     rsp_num_ff, rsp_num_in;
   logic                   rsp_mark_ff, rsp_mark_in;

   logic [WIDE_W-1:0]      max_wide;
   logic [WIDE_W-1:0]      lim_wide;
   logic                   lim_zero;
   logic                   num_valid;
   idx_type                num_idx;
   logic                   go_lookup;
   logic                   go_scan;

   logic                   ram_we;
   idx_type                ram_wr_idx;
   logic [ENTRY_W-1:0]     ram_wr_data;
   idx_type                rd_idx;
   logic [ENTRY_W-1:0]     ram_rd;
   vld_ctrl_type           vld_ctrl;
   vld_stat_type           vld_stat;

   logic [ADDR_W-1:0]      entry_addr;
   logic                   entry_mark;
   logic [CNT_W-1:0]       scan_pos;
   logic                   entry_match;
   logic                   scan_done;

   ntu_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_idx),
      .wr_data (ram_wr_data),
      .rd_addr (rd_idx),
      .rd_data (ram_rd)
   );

   ntu_vld u_vld (
      .clock (clock),
      .reset (reset),
      .ctrl  (vld_ctrl),
      .stat  (vld_stat)
   );

   // request decode against the current limit
   always_comb begin
      max_wide  = WIDE_W'(csr_max_ff);
      lim_wide  = (max_wide < WIDE_W'(TABLE_DEPTH)) ? max_wide : WIDE_W'(TABLE_DEPTH);
      lim_zero  = (lim_wide == '0);
      num_valid = (req_device_number != '0) && (WIDE_W'(req_device_number) <= lim_wide);
      num_idx   = idx_type'(req_device_number - NUM_W'(1));
      go_lookup = (req_action == ACT_GET_ADDR) && num_valid;
      go_scan   = ((req_action == ACT_GET_NUM) && (req_node_address != '0) && !lim_zero)
                  || ((req_action == ACT_ASSIGN) && !lim_zero);
   end

   // entry read last cycle; cleared addresses read as zero
   always_comb begin
      entry_addr  = vld_stat.addr_vld ? ram_rd[ADDR_W-1:0] : '0;
      entry_mark  = ram_rd[ADDR_W];
      scan_pos    = {1'b0, scan_idx_ff} + CNT_W'(1);
      entry_match = (entry_addr == key_ff);
      scan_done   = entry_match || (scan_pos == lim_ff);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (scan_idx_ff == idx_type'(TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (go_lookup) begin
                  state_in = ST_LOOKUP;
               end else if (go_scan) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_LOOKUP: begin
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ram_we       = 1'b0;
      ram_wr_idx   = num_idx;
      ram_wr_data  = {req_lamp_on, req_node_address};
      rd_idx       = num_idx;
      vld_ctrl     = '0;
      lim_in       = lim_ff;
      key_in       = key_ff;
      scan_idx_in  = scan_idx_ff;
      rsp_valid_in = 1'b0;
      rsp_ok_in    = 1'b0;
      rsp_addr_in  = '0;
      rsp_num_in   = '0;
      rsp_mark_in  = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            // zero one entry per cycle, address and mark
            ram_we      = 1'b1;
            ram_wr_idx  = scan_idx_ff;
            ram_wr_data = '0;
            scan_idx_in = scan_idx_ff + idx_type'(1);
         end
         ST_IDLE: begin
            lim_in      = CNT_W'(lim_wide);
            scan_idx_in = '0;
            if (start) begin
               unique case (req_action)
                  ACT_REPORT: begin
                     rsp_valid_in = 1'b1;
                     if (num_valid) begin
                        ram_we             = 1'b1;
                        vld_ctrl.set_entry = 1'b1;
                        rsp_ok_in          = 1'b1;
                        rsp_mark_in        = req_lamp_on;
                     end
                  end
                  ACT_GET_ADDR: begin
                     rsp_valid_in = !go_lookup;
                  end
                  ACT_GET_NUM: begin
                     rd_idx       = '0;
                     key_in       = req_node_address;
                     rsp_valid_in = !go_scan;
                  end
                  ACT_ASSIGN: begin
                     rd_idx       = '0;
                     key_in       = '0;
                     rsp_valid_in = !go_scan;
                  end
                  ACT_CLEAR: begin
                     vld_ctrl.clear_addr = 1'b1;
                     rsp_valid_in        = 1'b1;
                     rsp_ok_in           = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_LOOKUP: begin
            rsp_valid_in = 1'b1;
            rsp_ok_in    = 1'b1;
            rsp_addr_in  = entry_addr;
            rsp_mark_in  = entry_mark;
         end
         ST_SCAN: begin
            // prefetch the next entry while checking this one
            rd_idx      = idx_type'(scan_pos);
            scan_idx_in = idx_type'(scan_pos);
            if (entry_match) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b1;
               rsp_num_in   = FOUND_W'(scan_pos);
               rsp_mark_in  = entry_mark;
            end else if (scan_done) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
      vld_ctrl.wr_idx = num_idx;
      vld_ctrl.rd_idx = rd_idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         csr_max_ff   <= MAX_DEVICES_RESET;
         rsp_valid_ff <= 1'b0;
         scan_idx_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_idx_ff  <= scan_idx_in;
         if (csr_write_enable) begin
            csr_max_ff <= csr_write_data;
         end
      end
      lim_ff      <= lim_in;
      key_ff      <= key_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_num_ff  <= rsp_num_in;
      rsp_mark_ff <= rsp_mark_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_found_address = rsp_addr_ff;
   assign rsp_found_number  = rsp_num_ff;
   assign rsp_mark          = rsp_mark_ff;

   a_lookup_answers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOKUP) |=> (rsp_valid && (state_ff == ST_IDLE)))
      else $error("address lookup did not answer in the next cycle");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> ({1'b0, scan_idx_ff} < lim_ff))
      else $error("scan ran past the entry limit");

   a_result_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(start && !busy) || $past(busy)))
      else $error("result without a request");

   a_write_only_idle: assert property (@(posedge clock) disable iff (reset)
      ((ram_we && (state_ff != ST_INIT)) || vld_ctrl.clear_addr) |-> (start && !busy))
      else $error("table changed outside an accepted request");

endmodule

// ----- hdl/ntu_ram.sv -----
module ntu_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/ntu_vld.sv -----
module ntu_vld (
   input  logic                 clock,
   input  logic                 reset,
   input  ntu_pkg::vld_ctrl_type ctrl,
   output ntu_pkg::vld_stat_type stat
);

   import ntu_pkg::*;

   logic [TABLE_DEPTH-1:0] addr_vld_ff, addr_vld_in;
   vld_stat_type           stat_ff, stat_in;

   always_comb begin
      addr_vld_in = addr_vld_ff;
      // clear drops the addresses only; marks stay in the RAM
      if (ctrl.clear_addr) begin
         addr_vld_in = '0;
      end
      if (ctrl.set_entry) begin
         addr_vld_in[ctrl.wr_idx] = 1'b1;
      end
      stat_in.addr_vld = addr_vld_ff[ctrl.rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_vld_ff <= '0;
      end else begin
         addr_vld_ff <= addr_vld_in;
      end
      stat_ff <= stat_in;
   end

   assign stat = stat_ff;

endmodule
